[sv/pblw_pkg.sv]
// pblw_pkg: shared constants and types for the packed bitmap line walker
// no dependencies; imported by packed_bitmap_line_walker

`default_nettype none

package pblw_pkg;

  localparam int unsigned COORD_BITS     = 8;
  localparam int unsigned ERR_BITS       = COORD_BITS + 2;
  localparam int unsigned ROW_BYTES_BITS = 6;
  localparam int unsigned OFFSET_BITS    = 13;
  localparam int unsigned MASK_BITS      = 8;
  localparam int unsigned PROD_BITS      = ROW_BYTES_BITS + COORD_BITS;
  localparam int unsigned IN_DATA_BITS   = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_BITS  = ((OFFSET_BITS + MASK_BITS + 7) / 8) * 8;

  localparam logic [ROW_BYTES_BITS-1:0] ROW_BYTES_RESET = ROW_BYTES_BITS'(30);
  localparam logic [MASK_BITS-1:0]      MASK_LEFT       = 8'h80;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_e;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

endpackage : pblw_pkg

`default_nettype wire

[sv/packed_bitmap_line_walker.sv]
// packed_bitmap_line_walker: incremental line walker for a 1 bpp packed framebuffer
// depends on pblw_pkg for widths, reset values and the command codes
//
// usage:
//   slave stream carries commands; tuser is the op (start or advance), tdata the
//   start and end points. a start transfer loads a line and returns nothing.
//   each advance transfer on an active line returns one pixel on the master
//   stream as byte offset and msb-first bit mask; tlast marks the final pixel.
//   the end point itself is never returned, a zero-length line returns nothing,
//   and an advance while idle is dropped. the user must write row_bytes through
//   cfg_we_i / cfg_wdata_i only while the block is idle; nothing checks this.
// timing:
//   one command per cycle unless stalled; an advance's pixel is on the master
//   stream in the next cycle. the walker state and the output register are
//   the only stages, with one multiply and add for the offset between them.
// reset:
//   rst_ni clears the walker to idle, row_bytes returns to 30, no output valid.
// stall:
//   while a result waits with m_axis_tready low, s_axis_tready drops;
//   a taken result frees the register for a new command in the same cycle.

`default_nettype none

module packed_bitmap_line_walker
  import pblw_pkg::*;
(
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        cfg_we_i,
  input  wire  [ROW_BYTES_BITS-1:0]  cfg_wdata_i,     // row_bytes
  input  wire                        s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire  [IN_DATA_BITS-1:0]    s_axis_tdata,    // x_start, y_start, x_end, y_end
  input  wire                        s_axis_tuser,    // op
  output logic                       m_axis_tvalid,
  input  wire                        m_axis_tready,
  output logic [OUT_DATA_BITS-1:0]   m_axis_tdata,    // byte_offset, bit_mask
  output logic                       m_axis_tlast
);

  logic [ROW_BYTES_BITS-1:0] row_bytes_q;
  coord_t cur_col_q, cur_col_d, cur_row_q, cur_row_d;
  coord_t end_col_q, end_col_d, end_row_q, end_row_d;
  coord_t delta_col_q, delta_col_d, delta_row_q, delta_row_d;
  err_t   err_q, err_d;
  logic   col_inc_q, col_inc_d, row_inc_q, row_inc_d;
  logic   active_q, active_d;

  logic                     out_valid_q, out_valid_d;
  logic [OFFSET_BITS-1:0]   offset_q, offset_d;
  logic [MASK_BITS-1:0]     mask_q, mask_d;
  logic                     last_q, last_d;

  logic   accept;
  logic   produce;
  coord_t x0, y0, x1, y1;
  coord_t step_col, step_row;
  logic [PROD_BITS-1:0] row_base;
  err_t   dcol_ext, drow_ext;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign produce = accept && (op_e'(s_axis_tuser) == OP_ADVANCE) && active_q;

  assign x0 = s_axis_tdata[0*COORD_BITS +: COORD_BITS];
  assign y0 = s_axis_tdata[1*COORD_BITS +: COORD_BITS];
  assign x1 = s_axis_tdata[2*COORD_BITS +: COORD_BITS];
  assign y1 = s_axis_tdata[3*COORD_BITS +: COORD_BITS];

  assign s_axis_tready = !out_valid_q || m_axis_tready;

  assign step_col = col_inc_q ? cur_col_q + 1'b1 : cur_col_q - 1'b1;
  assign step_row = row_inc_q ? cur_row_q + 1'b1 : cur_row_q - 1'b1;
  assign dcol_ext = $signed({{(ERR_BITS-COORD_BITS){1'b0}}, delta_col_q});
  assign drow_ext = $signed({{(ERR_BITS-COORD_BITS){1'b0}}, delta_row_q});
  assign row_base = PROD_BITS'(row_bytes_q) * PROD_BITS'(cur_row_q);

  always_comb begin
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    end_col_d   = end_col_q;
    end_row_d   = end_row_q;
    delta_col_d = delta_col_q;
    delta_row_d = delta_row_q;
    err_d       = err_q;
    col_inc_d   = col_inc_q;
    row_inc_d   = row_inc_q;
    active_d    = active_q;
    offset_d    = OFFSET_BITS'(row_base + PROD_BITS'(cur_col_q >> 3));
    mask_d      = MASK_LEFT >> cur_col_q[2:0];
    last_d      = 1'b0;
    if (accept && op_e'(s_axis_tuser) == OP_START) begin
      cur_col_d   = x0;
      cur_row_d   = y0;
      end_col_d   = x1;
      end_row_d   = y1;
      col_inc_d   = x0 < x1;
      row_inc_d   = y0 < y1;
      delta_col_d = (x0 < x1) ? x1 - x0 : x0 - x1;
      delta_row_d = (y0 < y1) ? y1 - y0 : y0 - y1;
      err_d       = (x0 == x1) ? -err_t'(1) : '0;
      active_d    = (x0 != x1) || (y0 != y1);
    end else if (produce) begin
      if (err_q[ERR_BITS-1]) begin
        cur_row_d = step_row;
        err_d     = err_q + dcol_ext;
      end else begin
        cur_col_d = step_col;
        err_d     = err_q - drow_ext;
      end
      last_d = (cur_col_d == end_col_q) && (cur_row_d == end_row_q);
      if (last_d) begin
        active_d = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = produce;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q <= ROW_BYTES_RESET;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      end_col_q   <= '0;
      end_row_q   <= '0;
      delta_col_q <= '0;
      delta_row_q <= '0;
      err_q       <= '0;
      col_inc_q   <= 1'b0;
      row_inc_q   <= 1'b0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        row_bytes_q <= cfg_wdata_i;
      end
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      end_col_q   <= end_col_d;
      end_row_q   <= end_row_d;
      delta_col_q <= delta_col_d;
      delta_row_q <= delta_row_d;
      err_q       <= err_d;
      col_inc_q   <= col_inc_d;
      row_inc_q   <= row_inc_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (produce) begin
      offset_q <= offset_d;
      mask_q   <= mask_d;
      last_q   <= last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_BITS'({mask_q, offset_q});
  assign m_axis_tlast  = last_q;

  a_start_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && op_e'(s_axis_tuser) == OP_START |=> !m_axis_tvalid)
    else $error("start command produced a result");

  a_idle_advance_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && op_e'(s_axis_tuser) == OP_ADVANCE && !active_q |=> !m_axis_tvalid)
    else $error("advance on idle walker produced a result");

  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> !active_q)
    else $error("line still active after its last pixel");

  a_mask_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot(m_axis_tdata[OFFSET_BITS +: MASK_BITS]))
    else $error("bit mask not one-hot");

endmodule : packed_bitmap_line_walker

`default_nettype wire
